FILE: hdl/ccmc_pkg.sv
// ----------------------------------------------------------------------------
// ccmc_pkg
// Shared widths and the control/status structs of the coin change block.
// ----------------------------------------------------------------------------
package ccmc_pkg;

   localparam int COIN_W = 16;
   localparam int TGT_W  = 12;
   localparam int VAL_W  = 13;
   localparam int HELD_W = 7;

   typedef struct packed {
      logic              start;
      logic [TGT_W-1:0]  target;
      logic [HELD_W-1:0] held;
      logic              rsp_free;
   } ccmc_ctl_type;

   typedef struct packed {
      logic              en;
      logic [HELD_W-1:0] addr;
      logic [COIN_W-1:0] data;
   } ccmc_coin_wr_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic             reachable;
      logic [TGT_W-1:0] count;
   } ccmc_stat_type;

endpackage

FILE: hdl/ccmc_ram.sv
// ----------------------------------------------------------------------------
// ccmc_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ccmc_engine.sv
// ----------------------------------------------------------------------------
// ccmc_engine
// Coin store and count table, plus the sequencer that fills the table
// bottom up through a two stage read pipeline (coin read, table read).
// ----------------------------------------------------------------------------
module ccmc_engine #(
   parameter int MAX_AMOUNT = 4095,
   parameter int MAX_COINS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ccmc_pkg::ccmc_ctl_type     ctl,
   input  ccmc_pkg::ccmc_coin_wr_type coin_wr,
   output ccmc_pkg::ccmc_stat_type    stat
);
   import ccmc_pkg::*;

   localparam int AW = (MAX_AMOUNT + 1 > 1) ? $clog2(MAX_AMOUNT + 1) : 1;
   localparam int KW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_WALK,
      ST_DRAIN,
      ST_WRITE,
      ST_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [TGT_W-1:0]  tgt_ff, tgt_in;
   logic [TGT_W-1:0]  amt_ff, amt_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [HELD_W-1:0] k_ff, k_in;
   logic [VAL_W-1:0]  best_ff, best_in;
   logic [VAL_W-1:0]  last_best_ff, last_best_in;
   logic              p1_valid_ff, p1_valid_in;
   logic              p2_valid_ff, p2_valid_in;

   logic [COIN_W-1:0] coin_rd_data;
   logic              tbl_wr_en;
   logic [AW-1:0]     tbl_wr_addr;
   logic [VAL_W-1:0]  tbl_wr_data;
   logic              tbl_rd_en;
   logic [AW-1:0]     tbl_rd_addr;
   logic [VAL_W-1:0]  tbl_rd_data;
   logic [VAL_W-1:0]  unreach;
   logic [VAL_W-1:0]  cand;
   logic              reach;

   ccmc_ram #(.WIDTH(COIN_W), .DEPTH(MAX_COINS)) u_coin_ram (
      .clock   (clock),
      .wr_en   (coin_wr.en),
      .wr_addr (coin_wr.addr[KW-1:0]),
      .wr_data (coin_wr.data),
      .rd_en   (state_ff == ST_WALK),
      .rd_addr (k_ff[KW-1:0]),
      .rd_data (coin_rd_data)
   );

   ccmc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_AMOUNT + 1)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign unreach     = VAL_W'(tgt_ff) + VAL_W'(1);
   assign cand        = tbl_rd_data + VAL_W'(1);
   assign tbl_rd_en   = p1_valid_ff && (coin_rd_data != '0)
                        && (coin_rd_data <= COIN_W'(amt_ff));
   assign tbl_rd_addr = AW'(amt_ff - coin_rd_data[TGT_W-1:0]);
   assign tbl_wr_en   = (state_ff == ST_INIT) || (state_ff == ST_WRITE);
   assign tbl_wr_addr = (state_ff == ST_INIT) ? '0 : AW'(amt_ff);
   assign tbl_wr_data = (state_ff == ST_INIT) ? '0 : best_ff;
   assign reach       = last_best_ff <= VAL_W'(tgt_ff);

   always_comb begin
      state_in     = state_ff;
      tgt_in       = tgt_ff;
      amt_in       = amt_ff;
      held_in      = held_ff;
      k_in         = k_ff;
      best_in      = best_ff;
      last_best_in = last_best_ff;
      p1_valid_in  = (state_ff == ST_WALK);
      p2_valid_in  = tbl_rd_en;
      if (p2_valid_ff && (cand < best_ff)) begin
         best_in = cand;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               tgt_in   = ctl.target;
               held_in  = ctl.held;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (tgt_ff == '0) begin
               last_best_in = '0;
               state_in     = ST_FIN;
            end else begin
               amt_in   = TGT_W'(1);
               best_in  = unreach;
               k_in     = '0;
               state_in = (held_ff == '0) ? ST_WRITE : ST_WALK;
            end
         end
         ST_WALK: begin
            k_in = k_ff + HELD_W'(1);
            if (k_ff == held_ff - HELD_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            last_best_in = best_ff;
            if (amt_ff == tgt_ff) begin
               state_in = ST_FIN;
            end else begin
               amt_in   = amt_ff + TGT_W'(1);
               best_in  = unreach;
               k_in     = '0;
               state_in = (held_ff == '0) ? ST_WRITE : ST_WALK;
            end
         end
         ST_FIN: begin
            if (ctl.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
      end
      tgt_ff       <= tgt_in;
      amt_ff       <= amt_in;
      held_ff      <= held_in;
      k_ff         <= k_in;
      best_ff      <= best_in;
      last_best_ff <= last_best_in;
   end

   assign stat.busy      = (state_ff != ST_IDLE);
   assign stat.done      = (state_ff == ST_FIN);
   assign stat.reachable = reach;
   assign stat.count     = reach ? last_best_ff[TGT_W-1:0] : '0;

endmodule

FILE: hdl/coin_change_min_count_top.sv
// ----------------------------------------------------------------------------
// coin_change_min_count_top
// Fewest-coin change calculator: collects coin denominations, then fills a
// table of minimum coin counts up to the target and reports the result.
// ----------------------------------------------------------------------------
// A query is a series of coin transactions; the one with req_last_coin set
// is a coin too and carries the target (saturated to MAX_AMOUNT). Coins past
// MAX_COINS are ignored and reported on rsp_coins_dropped. Coin transactions
// are taken back to back while req_stall is low. The last one starts a table
// walk: each amount reads every stored coin, and one earlier table entry for
// each nonzero coin not above the amount, through the registered coin and
// table memories, drains that two-stage read pipeline and writes its entry
// back. req_stall stays high during the walk and while the finished result
// waits for the response register to be free.
module coin_change_min_count_top #(
   parameter int MAX_AMOUNT = 4095,
   parameter int MAX_COINS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_coin_value,
   input  logic [11:0] req_target_amount,
   input  logic        req_last_coin,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_reachable,
   output logic [11:0] rsp_coin_count,
   output logic        rsp_coins_dropped
);
   import ccmc_pkg::*;

   ccmc_ctl_type     ctl;
   ccmc_coin_wr_type coin_wr;
   ccmc_stat_type    stat;

   logic [HELD_W-1:0] held_ff, held_in;
   logic              ovf_ff, ovf_in;
   logic              drop_ff, drop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_reach_ff;
   logic [TGT_W-1:0]  rsp_count_ff;
   logic              rsp_drop_ff;
   logic              accept;
   logic              full;
   logic              load;
   logic [TGT_W-1:0]  tgt_sat;

   assign accept = req_valid && !req_stall;
   assign full   = (held_ff == HELD_W'(MAX_COINS));
   assign tgt_sat = (32'(req_target_amount) > MAX_AMOUNT) ? TGT_W'(MAX_AMOUNT)
                                                           : req_target_amount;

   assign coin_wr.en   = accept && !full;
   assign coin_wr.addr = held_ff;
   assign coin_wr.data = req_coin_value;

   assign ctl.start    = accept && req_last_coin;
   assign ctl.target   = tgt_sat;
   assign ctl.held     = full ? held_ff : held_ff + HELD_W'(1);
   assign ctl.rsp_free = !rsp_valid_ff || !rsp_stall;

   ccmc_engine #(.MAX_AMOUNT(MAX_AMOUNT), .MAX_COINS(MAX_COINS)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .coin_wr (coin_wr),
      .stat    (stat)
   );

   assign load = stat.done && ctl.rsp_free;

   always_comb begin
      held_in      = held_ff;
      ovf_in       = ovf_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         if (req_last_coin) begin
            held_in = '0;
            ovf_in  = 1'b0;
            drop_in = ovf_ff || full;
         end else begin
            held_in = ctl.held;
            ovf_in  = ovf_ff || full;
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      drop_ff <= drop_in;
      if (load) begin
         rsp_reach_ff <= stat.reachable;
         rsp_count_ff <= stat.count;
         rsp_drop_ff  <= drop_ff;
      end
   end

   assign req_stall         = stat.busy;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reachable     = rsp_reach_ff;
   assign rsp_coin_count    = rsp_count_ff;
   assign rsp_coins_dropped = rsp_drop_ff;

endmodule

FILE: hdl/ccmc_checker.sv
// ----------------------------------------------------------------------------
// ccmc_checker
// Port-level checks of the coin change block, bound to the top level.
// ----------------------------------------------------------------------------
module ccmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_coin,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_reachable,
   input logic [11:0] rsp_coin_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reachable |-> rsp_coin_count == 12'd0)
      else $error("nonzero count on unreachable result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_walk_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_coin |=> req_stall)
      else $error("last coin transaction did not start the walk");

endmodule

bind coin_change_min_count_top ccmc_checker u_ccmc_checker (.*);

FILE: tb/tb_coin_change_min_count_top.sv
// ----------------------------------------------------------------------------
// tb_coin_change_min_count_top
// Self-checking bench for the fewest-coin change calculator: coin set
// transactions go in from a queue through a clocked driver, and a clocked
// monitor predicts each query's result and compares rsp fields in order.
// ----------------------------------------------------------------------------
module tb_coin_change_min_count_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_AMOUNT = 4095;
   localparam int MAX_COINS  = 16;

   typedef enum int {PH_FREE, PH_SEND_GAP, PH_RCV_STALL, PH_BOTH} idle_phase_type;

   typedef struct {
      logic [15:0]    coin;
      logic [11:0]    tgt;
      logic           last;
      idle_phase_type phase;
   } coin_txn_type;

   typedef struct packed {
      logic        reachable;
      logic [11:0] count;
      logic        dropped;
   } change_result_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [15:0] req_coin_value    = '0;
   logic [11:0] req_target_amount = '0;
   logic        req_last_coin     = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic        rsp_reachable;
   logic [11:0] rsp_coin_count;
   logic        rsp_coins_dropped;

   logic           req_taken         = 1'b0;
   idle_phase_type active_phase      = PH_FREE;
   int             send_gap_pct[4]   = '{0, 73, 0, 11};
   int             rcv_stall_pct[4]  = '{0, 0, 73, 11};

   coin_txn_type       coin_txn_q[$];
   change_result_type  change_expect_q[$];
   int                 mismatch_cnt  = 0;
   longint             cycle_budget  = 0;
   longint             cycle_limit   = 64'd100000000;
   longint             cycle_cnt     = 0;

   // predictor state
   logic [15:0]     held_coins[MAX_COINS];
   int unsigned     held_cnt      = 0;
   logic            dropped_flag  = 1'b0;
   int unsigned     min_tbl[0:MAX_AMOUNT];

   coin_change_min_count_top #(
      .MAX_AMOUNT(MAX_AMOUNT),
      .MAX_COINS (MAX_COINS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coin_value   (req_coin_value),
      .req_target_amount(req_target_amount),
      .req_last_coin    (req_last_coin),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reachable    (rsp_reachable),
      .rsp_coin_count   (rsp_coin_count),
      .rsp_coins_dropped(rsp_coins_dropped)
   );

   always #2 clock = ~clock;

   task automatic tally_min_coins(input logic [15:0] coin, input logic [11:0] tgt,
                                  input logic last);
      int unsigned       amt;
      int unsigned       best;
      int unsigned       cand;
      int unsigned       c;
      change_result_type r;
      if (held_cnt < MAX_COINS) begin
         held_coins[held_cnt] = coin;
         held_cnt++;
      end else begin
         dropped_flag = 1'b1;
      end
      if (last) begin
         amt = (tgt > MAX_AMOUNT) ? MAX_AMOUNT : tgt;
         min_tbl[0] = 0;
         for (int unsigned i = 1; i <= amt; i++) begin
            best = amt + 1;
            for (int unsigned k = 0; k < held_cnt; k++) begin
               c = held_coins[k];
               if (c != 0 && c <= i) begin
                  cand = min_tbl[i - c] + 1;
                  if (cand < best) best = cand;
               end
            end
            min_tbl[i] = best;
         end
         r.reachable = (min_tbl[amt] <= amt);
         r.count     = r.reachable ? min_tbl[amt][11:0] : 12'd0;
         r.dropped   = dropped_flag;
         change_expect_q.push_back(r);
         held_cnt     = 0;
         dropped_flag = 1'b0;
      end
   endtask

   task automatic push_coin(input logic [15:0] coin, input logic [11:0] tgt,
                            input logic last, input idle_phase_type ph);
      coin_txn_type t;
      t.coin  = coin;
      t.tgt   = tgt;
      t.last  = last;
      t.phase = ph;
      coin_txn_q.push_back(t);
      cycle_budget += 64;
      if (last) cycle_budget += longint'(tgt + 1) * (MAX_COINS + 4);
   endtask

   // driver
   always @(negedge clock) begin
      coin_txn_type t;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (coin_txn_q.size() != 0 &&
                $urandom_range(99) >= send_gap_pct[coin_txn_q[0].phase]) begin
               t = coin_txn_q.pop_front();
               active_phase      = t.phase;
               req_coin_value    <= t.coin;
               req_target_amount <= t.tgt;
               req_last_coin     <= t.last;
               req_valid         <= 1'b1;
            end else begin
               req_valid         <= 1'b0;
               req_coin_value    <= 16'($urandom);
               req_target_amount <= 12'($urandom);
               req_last_coin     <= 1'($urandom);
            end
         end
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct[active_phase]);
      end
   end

   // monitor
   always @(posedge clock) begin
      change_result_type e;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            tally_min_coins(req_coin_value, req_target_amount, req_last_coin);
         if (rsp_valid && !rsp_stall) begin
            if (change_expect_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %b/%0d/%b",
                        $time, rsp_reachable, rsp_coin_count, rsp_coins_dropped);
               mismatch_cnt++;
            end else begin
               e = change_expect_q.pop_front();
               if (rsp_reachable !== e.reachable) begin
                  $display("%0t: reachable expected %b actual %b",
                           $time, e.reachable, rsp_reachable);
                  mismatch_cnt++;
               end
               if (rsp_coin_count !== e.count) begin
                  $display("%0t: coin_count expected %0d actual %0d",
                           $time, e.count, rsp_coin_count);
                  mismatch_cnt++;
               end
               if (rsp_coins_dropped !== e.dropped) begin
                  $display("%0t: coins_dropped expected %b actual %b",
                           $time, e.dropped, rsp_coins_dropped);
                  mismatch_cnt++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > cycle_limit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [15:0]    many_coins[17];
      int             queries;
      int             items;
      int             n;
      int             big_left;
      int             pick;
      logic [11:0]    tgt;
      logic [15:0]    coin;
      idle_phase_type ph;

      many_coins = '{7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                     16'h8000, 16'hFFFF, 0, 3, 1};

      // directed
      push_coin(16'd5, 12'd0, 1'b1, PH_FREE);           // zero target
      push_coin(16'd1, 12'd0, 1'b0, PH_FREE);
      push_coin(16'd2, 12'd0, 1'b0, PH_FREE);
      push_coin(16'd5, 12'd11, 1'b1, PH_FREE);
      push_coin(16'd2, 12'd3, 1'b1, PH_FREE);           // unreachable
      push_coin(16'd0, 12'hFFF, 1'b0, PH_FREE);         // zero coin
      push_coin(16'hFFFF, 12'd0, 1'b0, PH_FREE);
      push_coin(16'd3, 12'd9, 1'b1, PH_FREE);
      for (int i = 0; i < 17; i++)                      // overflow, largest target
         push_coin(many_coins[i], (i == 16) ? 12'd4095 : 12'($urandom),
                   i == 16, PH_FREE);

      // random
      queries  = 0;
      items    = 0;
      big_left = 2;
      while (items < 75) begin
         ph = idle_phase_type'((queries / 4) % 4);
         n  = ($urandom_range(99) < 10) ? $urandom_range(15, 20) : $urandom_range(1, 4);
         pick = $urandom_range(99);
         if (big_left > 0 && pick < 3) begin
            tgt = 12'($urandom_range(2048, 4095));
            big_left--;
         end else if (pick < 10) begin
            tgt = 12'($urandom_range(61, 600));
         end else begin
            tgt = 12'($urandom_range(0, 60));
         end
         for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)      coin = 16'($urandom_range(1, 12));
            else if (pick < 80) coin = 16'd0;
            else if (pick < 90) coin = 16'($urandom);
            else                coin = 16'($urandom_range(1, tgt + 1));
            push_coin(coin, (i == n - 1) ? tgt : 12'($urandom), i == n - 1, ph);
         end
         items += n;
         queries++;
      end
      cycle_limit = 4 * cycle_budget + 20000;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (coin_txn_q.size() != 0 || req_valid || change_expect_q.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      if (mismatch_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/ccmc_pkg.sv
hdl/ccmc_ram.sv
hdl/ccmc_engine.sv
hdl/coin_change_min_count_top.sv
hdl/ccmc_checker.sv
tb/tb_coin_change_min_count_top.sv
